FILE: rtl/core/i2c_master_byte_sequencer_assert.svh
`ifndef I2C_MASTER_BYTE_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_BYTE_SEQUENCER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define I2CMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define I2CMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/i2cms_pkg.sv
package i2cms_pkg;

	typedef enum logic [2:0] {
		OP_IDLE    = 3'd0,
		OP_START   = 3'd1,
		OP_RESTART = 3'd2,
		OP_STOP    = 3'd3,
		OP_WRITE   = 3'd4,
		OP_READ    = 3'd5
	} op_t;

	localparam logic [4:0] COND_STEPS     = 5'd4;
	localparam logic [4:0] STOP_STEPS     = 5'd3;
	localparam logic [4:0] BYTE_STEPS     = 5'd27;
	localparam logic [4:0] BIT_STEPS      = 5'd24;
	localparam logic [4:0] ACK_SMPL_STEP  = 5'd25;
	localparam logic [9:0] STEP_TICKS_RST = 10'd5;

	typedef struct packed {
		op_t        op;
		logic [4:0] idx;
		logic [9:0] wait_cnt;
		logic [1:0] bit_phase;
		logic [2:0] bit_num;
		logic [7:0] shift_byte;
		logic       ack_choice;
		logic       sda_pull;
		logic       scl_pull;
		logic       last_ack;
		logic [7:0] rx_byte;
	} seq_state_t;

	typedef struct packed {
		logic       sda_low;
		logic       scl_low;
		logic       busy;
		logic       done;
		logic [7:0] read_data;
		logic       ack_received;
		logic       rejected;
	} seq_res_t;

endpackage

FILE: rtl/core/i2cms_step.sv
module i2cms_step
	import i2cms_pkg::*;
(
	input  seq_state_t state_cur,
	input  logic [2:0] command,
	input  logic [7:0] data_byte,
	input  logic       send_ack,
	input  logic       sda_in,
	input  logic [9:0] step_ticks,
	output seq_state_t state_nxt,
	output seq_res_t   res
);

	typedef struct packed {
		logic sda;
		logic scl;
	} pins_t;

	function automatic logic [4:0] step_count(op_t op);
		logic [4:0] n;
		case (op)
			OP_START, OP_RESTART: n = COND_STEPS;
			OP_STOP:              n = STOP_STEPS;
			default:              n = BYTE_STEPS;
		endcase
		return n;
	endfunction

	function automatic pins_t apply_pins(op_t op, logic [4:0] i, logic [1:0] ph,
			logic [2:0] bn, logic [7:0] sh, logic ackc, logic sda, logic scl);
		pins_t      p;
		logic [4:0] rel;
		logic [1:0] phase;
		p.sda = sda;
		p.scl = scl;
		rel   = i - BIT_STEPS;
		phase = (i < BIT_STEPS) ? ph : rel[1:0];
		case (op)
			OP_START, OP_RESTART: begin
				if (i == 5'd0)      p.sda = 1'b0;
				else if (i == 5'd1) p.scl = 1'b0;
				else if (i == 5'd2) p.sda = 1'b1;
				else                p.scl = 1'b1;
			end
			OP_STOP: begin
				if (i == 5'd0)      p.sda = 1'b1;
				else if (i == 5'd1) p.scl = 1'b0;
				else                p.sda = 1'b0;
			end
			OP_WRITE, OP_READ: begin
				if (phase == 2'd0) begin
					if (i >= BIT_STEPS)     p.sda = (op == OP_READ) ? ackc : 1'b0;
					else if (op == OP_WRITE) p.sda = ~sh[3'd7 - bn];
					else                    p.sda = 1'b0;
				end else if (phase == 2'd1) begin
					p.scl = 1'b0;
				end else begin
					p.scl = 1'b1;
				end
			end
			default: ;
		endcase
		return p;
	endfunction

	op_t        cmd_op;
	logic       is_cmd;
	logic [9:0] load_val;
	logic [4:0] idx_inc;
	logic       done;
	logic       rej;
	pins_t      pins;

	assign cmd_op   = op_t'(command);
	assign is_cmd   = (cmd_op == OP_START) || (cmd_op == OP_RESTART) || (cmd_op == OP_STOP)
		|| (cmd_op == OP_WRITE) || (cmd_op == OP_READ);
	assign load_val = (step_ticks == 10'd0) ? 10'd1 : step_ticks;
	assign idx_inc  = state_cur.idx + 5'd1;

	always_comb begin
		state_nxt = state_cur;
		done      = 1'b0;
		rej       = 1'b0;
		pins      = '0;
		if (is_cmd) begin
			if (state_cur.op != OP_IDLE) begin
				rej = 1'b1;
			end else begin
				state_nxt.op        = cmd_op;
				state_nxt.idx       = 5'd0;
				state_nxt.bit_phase = 2'd0;
				state_nxt.bit_num   = 3'd0;
				if (cmd_op == OP_WRITE) state_nxt.shift_byte = data_byte;
				if (cmd_op == OP_READ) begin
					state_nxt.shift_byte = 8'd0;
					state_nxt.ack_choice = send_ack;
				end
				pins = apply_pins(cmd_op, 5'd0, 2'd0, 3'd0, state_nxt.shift_byte,
					state_nxt.ack_choice, state_cur.sda_pull, state_cur.scl_pull);
				state_nxt.sda_pull = pins.sda;
				state_nxt.scl_pull = pins.scl;
				state_nxt.wait_cnt = load_val;
			end
		end else if (state_cur.op != OP_IDLE) begin
			if (state_cur.wait_cnt > 10'd1) begin
				state_nxt.wait_cnt = state_cur.wait_cnt - 10'd1;
			end else begin
				// end of the current step
				if (state_cur.op == OP_WRITE && state_cur.idx == ACK_SMPL_STEP)
					state_nxt.last_ack = ~sda_in;
				if (state_cur.op == OP_READ && state_cur.idx < BIT_STEPS
						&& state_cur.bit_phase == 2'd1)
					state_nxt.shift_byte = {state_cur.shift_byte[6:0], sda_in};
				if (idx_inc >= step_count(state_cur.op)) begin
					if (state_cur.op == OP_READ) begin
						state_nxt.sda_pull = 1'b1;
						state_nxt.rx_byte  = state_nxt.shift_byte;
					end
					state_nxt.op        = OP_IDLE;
					state_nxt.idx       = 5'd0;
					state_nxt.wait_cnt  = 10'd0;
					state_nxt.bit_phase = 2'd0;
					state_nxt.bit_num   = 3'd0;
					done                = 1'b1;
				end else begin
					state_nxt.idx = idx_inc;
					if (state_cur.bit_phase == 2'd2) begin
						state_nxt.bit_phase = 2'd0;
						state_nxt.bit_num   = state_cur.bit_num + 3'd1;
					end else begin
						state_nxt.bit_phase = state_cur.bit_phase + 2'd1;
					end
					pins = apply_pins(state_cur.op, idx_inc, state_nxt.bit_phase,
						state_nxt.bit_num, state_nxt.shift_byte, state_cur.ack_choice,
						state_cur.sda_pull, state_cur.scl_pull);
					state_nxt.sda_pull = pins.sda;
					state_nxt.scl_pull = pins.scl;
					state_nxt.wait_cnt = load_val;
				end
			end
		end
	end

	always_comb begin
		res.sda_low      = state_nxt.sda_pull;
		res.scl_low      = state_nxt.scl_pull;
		res.busy         = (state_nxt.op != OP_IDLE);
		res.done         = done;
		res.read_data    = state_nxt.rx_byte;
		res.ack_received = state_nxt.last_ack;
		res.rejected     = rej;
	end

endmodule

FILE: rtl/core/i2c_master_byte_sequencer.sv
// channel | handshake           | payload
// in      | in_valid / in_stall   | command, data_byte, send_ack, sda_in
// out     | out_valid / out_stall | sda_low, scl_low, busy_res, done_res,
//         |                       | read_data, ack_received, rejected
// cfg     | cfg_valid / cfg_ready | cfg_data (step_ticks)
//
// one result beat per input beat, one beat per cycle while the result is not stalled
// an item passes through the input register and then the result register; the sequencer state
// updates in the cycle an item moves into the result register
// reset clears all control and sequencer state, step_ticks returns to 5
// a stalled result holds; one more input beat is taken and waits in the input register
module i2c_master_byte_sequencer
	import i2cms_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] command,
	input  logic [7:0] data_byte,
	input  logic       send_ack,
	input  logic       sda_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       sda_low,
	output logic       scl_low,
	output logic       busy_res,
	output logic       done_res,
	output logic [7:0] read_data,
	output logic       ack_received,
	output logic       rejected,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [9:0] cfg_data
);

`include "i2c_master_byte_sequencer_assert.svh"

	logic       valid_s1;
	logic [2:0] command_s1;
	logic [7:0] data_byte_s1;
	logic       send_ack_s1;
	logic       sda_in_s1;
	logic       valid_s2;
	seq_res_t   res_s2;
	seq_state_t state_q;
	seq_state_t state_nxt;
	seq_res_t   res_nxt;
	logic [9:0] step_ticks_q;
	logic       out_free;
	logic       proc_en;
	logic       in_take;

	assign out_free  = !valid_s2 || !out_stall;
	assign proc_en   = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_ticks_q <= STEP_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			step_ticks_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (proc_en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			command_s1   <= command;
			data_byte_s1 <= data_byte;
			send_ack_s1  <= send_ack;
			sda_in_s1    <= sda_in;
		end
	end

	i2cms_step u_step (
		.state_cur  (state_q),
		.command    (command_s1),
		.data_byte  (data_byte_s1),
		.send_ack   (send_ack_s1),
		.sda_in     (sda_in_s1),
		.step_ticks (step_ticks_q),
		.state_nxt  (state_nxt),
		.res        (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (proc_en) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (proc_en) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc_en) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid    = valid_s2;
	assign sda_low      = res_s2.sda_low;
	assign scl_low      = res_s2.scl_low;
	assign busy_res     = res_s2.busy;
	assign done_res     = res_s2.done;
	assign read_data    = res_s2.read_data;
	assign ack_received = res_s2.ack_received;
	assign rejected     = res_s2.rejected;

	`I2CMS_ASSERT_NOW(a_busy_has_wait, clk, arst_n, state_q.op != OP_IDLE, state_q.wait_cnt != 10'd0, "busy sequencer with zero hold count")
	`I2CMS_ASSERT_NOW(a_idle_index_zero, clk, arst_n, state_q.op == OP_IDLE, state_q.idx == 5'd0, "idle sequencer with nonzero step index")
	`I2CMS_ASSERT_NEXT(a_idle_no_reject, clk, arst_n, proc_en && state_q.op == OP_IDLE, !res_s2.rejected, "command rejected while idle")
	`I2CMS_ASSERT_NEXT(a_stall_holds_state, clk, arst_n, valid_s2 && out_stall, $stable(state_q), "sequencer state moved while result beat stalled")

endmodule
